// ===== sv/integer_table_engine_top_assert.svh =====
// Assertion macros shared by the integer table engine modules.
// Needs signals named clk and arst_n in the including module.
`ifndef INTEGER_TABLE_ENGINE_TOP_ASSERT_SVH
`define INTEGER_TABLE_ENGINE_TOP_ASSERT_SVH

// checked only while out of reset
`define ITE_ASSERT(label, prop) \
label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ite assertion failed");

// checked at every edge, reset included
`define ITE_ASSERT_NR(label, prop) \
label: assert property (@(posedge clk) prop) \
	else $error("ite assertion failed");

`endif

// ===== sv/ite_pkg.sv =====
// Shared types and constants of the integer table engine.
// No dependencies.
package ite_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 6;
	localparam int DIV_W   = 16;
	localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		ACT_RESTART = 3'd0,
		ACT_APPEND  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_SORT    = 3'd3,
		ACT_LIST    = 3'd4,
		ACT_MAX     = 3'd5,
		ACT_PRIMES  = 3'd6,
		ACT_SEARCH  = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		KIND_DONE    = 3'd0,
		KIND_ELEMENT = 3'd1,
		KIND_MAX     = 3'd2,
		KIND_PRIME   = 3'd3,
		KIND_MATCH   = 3'd4,
		KIND_NONE    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	// prime tester result
	typedef struct packed {
		logic done;
		logic prime;
	} prm_res_t;

endpackage

// ===== sv/ite_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ite_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// output holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ite_prime.sv =====
// Trial-division prime tester: squares the divisor, then a bit-serial remainder.
// Depends on ite_pkg and integer_table_engine_top_assert.svh.
`include "integer_table_engine_top_assert.svh"
module ite_prime (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ite_pkg::DATA_W-1:0] value,
	output ite_pkg::prm_res_t         res
);

	typedef enum logic [3:0] {
		P_IDLE = 4'b0001,
		P_SQ   = 4'b0010,
		P_CMP  = 4'b0100,
		P_DIV  = 4'b1000
	} pstate_t;

	pstate_t                        state_q;
	logic [ite_pkg::DATA_W-1:0]     v_q;
	logic [ite_pkg::DIV_W-1:0]      d_q;
	logic [ite_pkg::DATA_W-1:0]     sq_q;
	logic [ite_pkg::DIV_W-1:0]      rem_q;
	logic [ite_pkg::DATA_W-1:0]     sh_q;
	logic [$clog2(ite_pkg::DATA_W)-1:0] bit_q;
	ite_pkg::prm_res_t              res_q;

	logic [ite_pkg::DIV_W:0]        r_trial;
	logic                           r_ge;
	logic [ite_pkg::DIV_W-1:0]      rem_n;

	always_comb begin
		r_trial = {rem_q, sh_q[ite_pkg::DATA_W-1]};
		r_ge    = (r_trial >= {1'b0, d_q});
		rem_n   = r_ge ? ite_pkg::DIV_W'(r_trial - {1'b0, d_q})
		               : r_trial[ite_pkg::DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						v_q <= value;
						if (value[ite_pkg::DATA_W-1] || (value < ite_pkg::DATA_W'(2))) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b0;
						end else begin
							d_q     <= ite_pkg::DIV_W'(2);
							state_q <= P_SQ;
						end
					end
				end
				P_SQ: begin
					sq_q    <= ite_pkg::DATA_W'(d_q) * ite_pkg::DATA_W'(d_q);
					state_q <= P_CMP;
				end
				P_CMP: begin
					if (sq_q > v_q) begin
						res_q.done  <= 1'b1;
						res_q.prime <= 1'b1;
						state_q     <= P_IDLE;
					end else begin
						rem_q   <= '0;
						sh_q    <= v_q;
						bit_q   <= '1;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					rem_q <= rem_n;
					sh_q  <= sh_q << 1;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						if (rem_n == '0) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b0;
							state_q     <= P_IDLE;
						end else begin
							// 2, then odd divisors only
							d_q     <= (d_q == ite_pkg::DIV_W'(2)) ? ite_pkg::DIV_W'(3)
							                                       : d_q + ite_pkg::DIV_W'(2);
							state_q <= P_SQ;
						end
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign res = res_q;

	`ITE_ASSERT(a_rem_below_div, (state_q == P_DIV) |-> (rem_q < d_q))
	`ITE_ASSERT(a_div_min_two, (state_q != P_IDLE) |-> (d_q >= ite_pkg::DIV_W'(2)))
	`ITE_ASSERT_NR(a_prime_ge_two, (res_q.done && res_q.prime) |-> (!v_q[ite_pkg::DATA_W-1] && (v_q >= ite_pkg::DATA_W'(2))))

endmodule

// ===== sv/integer_table_engine_top.sv =====
// Integer table engine top level: action sequencer around the table RAM.
// Depends on ite_pkg, ite_ram, ite_prime and integer_table_engine_top_assert.svh.
//
// Usage: one action per transfer on the s_ side (s_tuser = action, s_tdata =
// value and position). Results leave on the m_ side, m_tlast set on the final
// result of each action. Every action yields at least one result.
// Items are worked one at a time; s_tready is high only while the sequencer idles.
// Restart and append go straight to the finish state and the output register. Delete,
// list, maximum and search read the RAM one entry at a time (read, then process; list
// and search also decide), bounded by the single RAM read port. Sort is a bubble pass,
// repeated until a pass makes no swap (at most n passes). Primes spends per entry up to
// about sqrt(v)/2 trial divisors in the tester, each squared, compared and divided.
// Reset (arst_n low) empties the table and drops any pending result; table
// contents are not cleared and are never read before written.
// A stalled receiver (m_tready low) holds the output register; the sequencer
// then waits at its next result, and a new item may be taken as soon as the
// last result of the previous one is in the output register.
`include "integer_table_engine_top_assert.svh"
module integer_table_engine_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [ite_pkg::IN_TDATA_W-1:0] s_tdata,   // value[31:0], position[37:32], zero pad
	input  logic [2:0]                    s_tuser,   // action[2:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [ite_pkg::OUT_TDATA_W-1:0] m_tdata, // result_value[31:0], result_index[37:32], zero pad
	output logic [4:0]                     m_tuser,  // kind[2:0], status[4:3]
	output logic m_tlast
);

	localparam int IW = ite_pkg::IDX_W;
	localparam int CW = ite_pkg::CNT_W;
	localparam int DW = ite_pkg::DATA_W;
	localparam int PW = ite_pkg::POS_W;
	localparam int CMPW = PW + 1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_READ    = 7'b0000010,
		ST_PROC    = 7'b0000100,
		ST_PRIME   = 7'b0001000,
		ST_DECIDE  = 7'b0010000,
		ST_SORTEND = 7'b0100000,
		ST_FINISH  = 7'b1000000
	} state_t;

	state_t           state_q;
	ite_pkg::action_t act_q;
	logic [DW-1:0]    value_q;
	logic [PW-1:0]    pos_q;
	logic [CW-1:0]    fill_q;
	logic [IW-1:0]    ptr_q;
	logic [DW-1:0]    carry_q;     // sort: largest so far in the pass
	logic             swapped_q;
	logic [DW-1:0]    best_q;
	logic [IW-1:0]    best_idx_q;
	logic             hit_q;

	// result held back until the next one (or the end) decides tlast
	logic             pend_v_q;
	ite_pkg::kind_t   pend_kind_q;
	ite_pkg::status_t pend_status_q;
	logic [DW-1:0]    pend_value_q;
	logic [PW-1:0]    pend_index_q;

	// output register
	logic             m_valid_q;
	ite_pkg::kind_t   m_kind_q;
	ite_pkg::status_t m_status_q;
	logic [DW-1:0]    m_value_q;
	logic [PW-1:0]    m_index_q;
	logic             m_last_q;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [DW-1:0]    ram_wdata;
	logic             ram_re;
	logic [DW-1:0]    ram_rdata;

	logic              prm_start;
	ite_pkg::prm_res_t prm_res;

	logic             can_load;
	logic             out_load;
	ite_pkg::kind_t   out_kind;
	ite_pkg::status_t out_status;
	logic [DW-1:0]    out_value;
	logic [PW-1:0]    out_index;
	logic             out_last;

	logic             last_elem;
	logic             carry_gt;
	logic             new_best;
	logic             at_pos;
	ite_pkg::action_t in_act;
	logic [DW-1:0]    in_value;
	logic [PW-1:0]    in_pos;
	logic             hold_decide;
	ite_pkg::kind_t   hit_kind;

	assign in_act   = ite_pkg::action_t'(s_tuser);
	assign in_value = s_tdata[DW-1:0];
	assign in_pos   = s_tdata[DW+PW-1:DW];

	assign can_load  = !m_valid_q || m_tready;
	assign last_elem = (CW'(ptr_q) == fill_q - CW'(1));
	assign carry_gt  = $signed(carry_q) > $signed(ram_rdata);
	assign new_best  = (ptr_q == '0) || ($signed(ram_rdata) > $signed(best_q));
	assign at_pos    = (PW'(ptr_q) == pos_q);
	assign hold_decide = hit_q && pend_v_q && !can_load;

	always_comb begin
		unique case (act_q)
			ite_pkg::ACT_PRIMES: hit_kind = ite_pkg::KIND_PRIME;
			ite_pkg::ACT_SEARCH: hit_kind = ite_pkg::KIND_MATCH;
			default:             hit_kind = ite_pkg::KIND_ELEMENT;
		endcase
	end

	always_comb begin
		ram_re     = (state_q == ST_READ);
		ram_we     = 1'b0;
		ram_waddr  = ptr_q;
		ram_wdata  = ram_rdata;
		prm_start  = 1'b0;
		out_load   = 1'b0;
		out_kind   = pend_kind_q;
		out_status = pend_status_q;
		out_value  = pend_value_q;
		out_index  = pend_index_q;
		out_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (in_act == ite_pkg::ACT_APPEND) && (fill_q != ite_pkg::FULL_CNT)) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(fill_q);
					ram_wdata = in_value;
				end
			end
			ST_PROC: begin
				if (act_q == ite_pkg::ACT_DELETE) begin
					// shift down over the removed slot
					if (!at_pos) begin
						ram_we    = 1'b1;
						ram_waddr = ptr_q - IW'(1);
					end
				end else if (act_q == ite_pkg::ACT_SORT) begin
					if (ptr_q != '0) begin
						ram_we    = 1'b1;
						ram_waddr = ptr_q - IW'(1);
						ram_wdata = carry_gt ? ram_rdata : carry_q;
					end
				end else if (act_q == ite_pkg::ACT_PRIMES) begin
					prm_start = 1'b1;
				end
			end
			ST_SORTEND: begin
				ram_we    = 1'b1;
				ram_wdata = carry_q;
			end
			ST_DECIDE: begin
				if (hit_q && pend_v_q && can_load) begin
					out_load = 1'b1;
				end
			end
			ST_FINISH: begin
				if (can_load) begin
					out_load = 1'b1;
					out_last = 1'b1;
					if (!pend_v_q) begin
						out_kind   = ite_pkg::KIND_NONE;
						out_status = (fill_q == '0) ? ite_pkg::STAT_EMPTY : ite_pkg::STAT_OK;
						out_value  = '0;
						out_index  = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	ite_ram #(
		.ADDR_W (IW),
		.DATA_W (DW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	ite_prime u_prime (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (prm_start),
		.value  (ram_rdata),
		.res    (prm_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q  <= 1'b1;
			m_kind_q   <= out_kind;
			m_status_q <= out_status;
			m_value_q  <= out_value;
			m_index_q  <= out_index;
			m_last_q   <= out_last;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			pend_v_q  <= 1'b0;
			swapped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q         <= in_act;
						value_q       <= in_value;
						pos_q         <= in_pos;
						ptr_q         <= '0;
						swapped_q     <= 1'b0;
						pend_v_q      <= 1'b0;
						pend_kind_q   <= ite_pkg::KIND_DONE;
						pend_status_q <= ite_pkg::STAT_OK;
						pend_value_q  <= '0;
						pend_index_q  <= '0;
						unique case (in_act)
							ite_pkg::ACT_RESTART: begin
								fill_q   <= '0;
								pend_v_q <= 1'b1;
								state_q  <= ST_FINISH;
							end
							ite_pkg::ACT_APPEND: begin
								pend_v_q     <= 1'b1;
								pend_value_q <= in_value;
								if (fill_q == ite_pkg::FULL_CNT) begin
									pend_status_q <= ite_pkg::STAT_FULL;
								end else begin
									fill_q       <= fill_q + CW'(1);
									pend_index_q <= PW'(fill_q);
								end
								state_q <= ST_FINISH;
							end
							ite_pkg::ACT_DELETE: begin
								if (CMPW'(in_pos) >= CMPW'(fill_q)) begin
									pend_v_q      <= 1'b1;
									pend_status_q <= ite_pkg::STAT_BADPOS;
									pend_index_q  <= in_pos;
									state_q       <= ST_FINISH;
								end else begin
									ptr_q   <= IW'(in_pos);
									state_q <= ST_READ;
								end
							end
							ite_pkg::ACT_SORT: begin
								if (fill_q <= CW'(1)) begin
									pend_v_q <= 1'b1;
									state_q  <= ST_FINISH;
								end else begin
									state_q <= ST_READ;
								end
							end
							ite_pkg::ACT_MAX: begin
								if (fill_q == '0) begin
									pend_v_q      <= 1'b1;
									pend_kind_q   <= ite_pkg::KIND_MAX;
									pend_status_q <= ite_pkg::STAT_EMPTY;
									state_q       <= ST_FINISH;
								end else begin
									state_q <= ST_READ;
								end
							end
							default: begin
								// list, primes, search; empty table gives a none result
								state_q <= (fill_q == '0) ? ST_FINISH : ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					unique case (act_q)
						ite_pkg::ACT_DELETE: begin
							if (at_pos) begin
								pend_value_q <= ram_rdata;
							end
							if (last_elem) begin
								fill_q       <= fill_q - CW'(1);
								pend_v_q     <= 1'b1;
								pend_index_q <= pos_q;
								state_q      <= ST_FINISH;
							end else begin
								ptr_q   <= ptr_q + IW'(1);
								state_q <= ST_READ;
							end
						end
						ite_pkg::ACT_SORT: begin
							if ((ptr_q == '0) || !carry_gt) begin
								carry_q <= ram_rdata;
							end else begin
								swapped_q <= 1'b1;
							end
							if (last_elem) begin
								state_q <= ST_SORTEND;
							end else begin
								ptr_q   <= ptr_q + IW'(1);
								state_q <= ST_READ;
							end
						end
						ite_pkg::ACT_MAX: begin
							if (new_best) begin
								best_q     <= ram_rdata;
								best_idx_q <= ptr_q;
							end
							if (last_elem) begin
								pend_v_q     <= 1'b1;
								pend_kind_q  <= ite_pkg::KIND_MAX;
								pend_value_q <= new_best ? ram_rdata : best_q;
								pend_index_q <= new_best ? PW'(ptr_q) : PW'(best_idx_q);
								state_q      <= ST_FINISH;
							end else begin
								ptr_q   <= ptr_q + IW'(1);
								state_q <= ST_READ;
							end
						end
						ite_pkg::ACT_PRIMES: begin
							state_q <= ST_PRIME;
						end
						ite_pkg::ACT_LIST: begin
							hit_q   <= 1'b1;
							state_q <= ST_DECIDE;
						end
						ite_pkg::ACT_SEARCH: begin
							hit_q   <= (ram_rdata == value_q);
							state_q <= ST_DECIDE;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_PRIME: begin
					if (prm_res.done) begin
						hit_q   <= prm_res.prime;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// a new hit pushes the held one out with tlast low
					if (!hold_decide) begin
						if (hit_q) begin
							pend_v_q      <= 1'b1;
							pend_kind_q   <= hit_kind;
							pend_status_q <= ite_pkg::STAT_OK;
							pend_value_q  <= ram_rdata;
							pend_index_q  <= PW'(ptr_q);
						end
						if (last_elem) begin
							state_q <= ST_FINISH;
						end else begin
							ptr_q   <= ptr_q + IW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_SORTEND: begin
					if (swapped_q) begin
						swapped_q <= 1'b0;
						ptr_q     <= '0;
						state_q   <= ST_READ;
					end else begin
						pend_v_q      <= 1'b1;
						pend_kind_q   <= ite_pkg::KIND_DONE;
						pend_status_q <= ite_pkg::STAT_OK;
						pend_value_q  <= '0;
						pend_index_q  <= '0;
						state_q       <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_load) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = ite_pkg::OUT_TDATA_W'({m_index_q, m_value_q});
	assign m_tuser  = {m_status_q, m_kind_q};
	assign m_tlast  = m_last_q;

	`ITE_ASSERT_NR(a_fill_bound, fill_q <= ite_pkg::FULL_CNT)
	`ITE_ASSERT(a_write_in_table, ram_we |-> (CW'(ram_waddr) <= fill_q))
	`ITE_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready)

endmodule
